### rtl/bns_pkg.sv
// Shared types, constants and lookup tables for the buzzer note sequencer.
// No dependencies; used by buzzer_note_sequencer_core.
package bns_pkg;

	localparam int SONG_DEPTH_DEF = 32768;
	localparam int NOTE_COUNT     = 96;
	localparam int EFFECT_LENGTH  = 16;
	localparam int FX_COUNT       = 5;
	localparam int FX_ROW_LEN     = 16;
	localparam int FX_SHORT_LEN   = 4;
	localparam int FX_START_POS   = 2;
	localparam int SEMITONES      = 12;
	localparam int RECORD_LEN     = 5;

	// ASCII codes found in a note record
	localparam logic [7:0] CH_A     = "A";
	localparam logic [7:0] CH_B     = "B";
	localparam logic [7:0] CH_C     = "C";
	localparam logic [7:0] CH_D     = "D";
	localparam logic [7:0] CH_E     = "E";
	localparam logic [7:0] CH_F     = "F";
	localparam logic [7:0] CH_G     = "G";
	localparam logic [7:0] CH_SHARP = "#";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] END_MARK = CH_F;

	typedef enum logic [2:0] {
		KIND_TICK     = 3'd0,
		KIND_WRITE    = 3'd1,
		KIND_PLAY     = 3'd2,
		KIND_LOOP     = 3'd3,
		KIND_HALT     = 3'd4,
		KIND_EFFECT   = 3'd5,
		KIND_UNLOAD   = 3'd6,
		KIND_NOP      = 3'd7
	} kind_t;

	localparam logic [15:0] TONE_ROM [NOTE_COUNT] = '{
		16'd65535, 16'd65535, 16'd65535, 16'd62799, 16'd56818, 16'd54235,
		16'd51877, 16'd49716, 16'd45892, 16'd44192, 16'd41144, 16'd38490,
		16'd36157, 16'd34091, 16'd32248, 16'd30594, 16'd29102, 16'd27118,
		16'd25939, 16'd24351, 16'd22946, 16'd21694, 16'd20572, 16'd19245,
		16'd18357, 16'd17292, 16'd16345, 16'd15297, 16'd14551, 16'd13715,
		16'd12969, 16'd12175, 16'd11473, 16'd10847, 16'd10286, 16'd9701,
		16'd9108,  16'd8584,  16'd8117,  16'd7698,  16'd7231,  16'd6818,
		16'd6450,  16'd6088,  16'd5736,  16'd5424,  16'd5121,  16'd4870,
		16'd4554,  16'd4308,  16'd4058,  16'd3837,  16'd3616,  16'd3419,
		16'd3225,  16'd3044,  16'd2875,  16'd2712,  16'd2560,  16'd2415,
		16'd2281,  16'd2154,  16'd2033,  16'd1918,  16'd1811,  16'd1709,
		16'd1612,  16'd1522,  16'd1436,  16'd1356,  16'd1280,  16'd1208,
		16'd1141,  16'd1076,  16'd1015,  16'd959,   16'd898,   16'd854,
		16'd806,   16'd761,   16'd718,   16'd678,   16'd640,   16'd604,
		16'd570,   16'd538,   16'd508,   16'd479,   16'd452,   16'd427,
		16'd403,   16'd380,   16'd359,   16'd339,   16'd320,   16'd302
	};

	localparam logic [7:0] FX_ROM [FX_COUNT][FX_ROW_LEN] = '{
		'{8'd56, 8'd52, 8'd51, 8'd45, 8'd0, 8'd0, 8'd0, 8'd0,
		  8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
		'{8'd0, 8'd0, 8'd90, 8'd80, 8'd70, 8'd60, 8'd50, 8'd30,
		  8'd10, 8'd5, 8'd10, 8'd30, 8'd50, 8'd60, 8'd70, 8'd60},
		'{8'd0, 8'd0, 8'd69, 8'd3, 8'd120, 8'd32, 8'd39, 8'd200,
		  8'd20, 8'd60, 8'd16, 8'd106, 8'd12, 8'd87, 8'd8, 8'd70},
		'{8'd0, 8'd0, 8'd30, 8'd35, 8'd40, 8'd43, 8'd44, 8'd45,
		  8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53},
		'{8'd0, 8'd0, 8'd69, 8'd70, 8'd71, 8'd72, 8'd69, 8'd64,
		  8'd58, 8'd40, 8'd30, 8'd12, 8'd12, 8'd16, 8'd20, 8'd70}
	};

	// index above the top note clamps to the top note
	function automatic logic [15:0] tone_of(input logic [7:0] idx);
		logic [6:0] i;
		if (idx > 8'(NOTE_COUNT - 1)) begin
			i = 7'(NOTE_COUNT - 1);
		end else begin
			i = idx[6:0];
		end
		return TONE_ROM[i];
	endfunction

	function automatic logic [7:0] fx_entry(input logic [2:0] sel, input logic [3:0] pos);
		logic [7:0] e;
		if (sel < 3'(FX_COUNT)) begin
			e = FX_ROM[sel][pos];
		end else begin
			e = FX_ROM[0][pos];
		end
		return e;
	endfunction

	// letter + sharp mark -> 1..12, 0 = rest
	function automatic logic [3:0] note_code(input logic [7:0] letter, input logic [7:0] mark);
		logic sharp;
		logic [3:0] c;
		sharp = (mark == CH_SHARP);
		case (letter)
			CH_C:    c = sharp ? 4'd2 : 4'd1;
			CH_D:    c = sharp ? 4'd4 : 4'd3;
			CH_E:    c = 4'd5;
			CH_F:    c = sharp ? 4'd7 : 4'd6;
			CH_G:    c = sharp ? 4'd9 : 4'd8;
			CH_A:    c = sharp ? 4'd11 : 4'd10;
			CH_B:    c = 4'd12;
			default: c = 4'd0;
		endcase
		return c;
	endfunction

endpackage

### rtl/buzzer_note_sequencer_core.sv
// Buzzer note sequencer top level: command decode, effect and music stepping.
// Depends on bns_pkg and bns_ram (song memory).
//
// Takes one command word per accepted cycle and returns exactly one result word for each.
// Song writes, play/loop/halt/unload/effect commands and ticks not needing the next note
// record finish at accept, so such words can be accepted back to back. A tick that
// needs the next record (a new note or the end mark) reads four record bytes through the
// single read port of the song RAM in the fetch state; the input stays not ready until
// its result is in the output register. A new word is taken only while the result
// register is empty or is being read in that same cycle, so a stalled result holds off
// the input. Song memory is not cleared at reset; there is no clearing pass, and playing
// bytes never written gives unspecified tones.
module buzzer_note_sequencer_core #(
	parameter int SONG_DEPTH = bns_pkg::SONG_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // song_addr[14:0], song_byte[22:15], effect_id[30:23]
	input  logic [2:0]  s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // speaker_on[0], divisor[16:1], music_done[17]
	output logic        m_axis_tuser,   // divisor_valid
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data     // audio_enable
);

	localparam int AW = $clog2(SONG_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_FETCH = 2'b10
	} state_t;

	function automatic logic [AW-1:0] addr_mod(input logic [14:0] a);
		logic [31:0] r;
		r = {17'd0, a};
		for (int j = 4; j >= 0; j--) begin
			if (r >= (32'(SONG_DEPTH) << j)) begin
				r = r - (32'(SONG_DEPTH) << j);
			end
		end
		return r[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] off, input logic [2:0] k);
		logic [AW:0] s;
		s = {1'b0, off} + {{(AW-2){1'b0}}, k};
		if (s >= (AW+1)'(SONG_DEPTH)) begin
			s = s - (AW+1)'(SONG_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// input word fields
	bns_pkg::kind_t kind;
	logic [14:0] song_addr;
	logic [7:0]  song_byte;
	logic [7:0]  effect_id;
	assign kind      = bns_pkg::kind_t'(s_axis_tuser);
	assign song_addr = s_axis_tdata[14:0];
	assign song_byte = s_axis_tdata[22:15];
	assign effect_id = s_axis_tdata[30:23];

	state_t      state_q;
	logic [1:0]  fetch_cnt_q;
	logic [7:0]  dur_q, letter_q, mark_q;
	logic        pend_dv_q;
	logic [15:0] pend_dval_q;

	logic [AW-1:0] play_offset_q;
	logic [7:0]  note_ticks_q, note_length_q;
	logic        music_once_q, music_loop_q, song_loaded_q;
	logic        effect_active_q;
	logic [2:0]  effect_select_q;
	logic [4:0]  effect_pos_q;
	logic        gate_q;
	logic        audio_enable_q;

	logic        out_valid_q, out_gate_q, out_dv_q, out_done_q;
	logic [15:0] out_dval_q;

	logic [AW-1:0] nx_offset;
	logic [7:0]  nx_ticks, nx_length;
	logic        nx_once, nx_loop, nx_loaded, nx_eff_act, nx_gate;
	logic [2:0]  nx_eff_sel;
	logic [4:0]  nx_eff_pos;
	logic        o_dv, o_done, load_out, fetch_start, fetch_last;
	logic [15:0] o_dval;
	logic [4:0]  eff_len;
	logic [7:0]  fx_e;
	logic [3:0]  code;
	logic [7:0]  octv, idx;
	logic        in_accept, ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]  ram_rdata;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready);
	assign fetch_last = (state_q == ST_FETCH) && (fetch_cnt_q == 2'd3);

	assign eff_len = (effect_select_q == 3'd0) ? 5'(bns_pkg::FX_SHORT_LEN)
	                                           : 5'(bns_pkg::EFFECT_LENGTH);
	assign fx_e = bns_pkg::fx_entry(effect_select_q, effect_pos_q[3:0]);

	// record decode; octave byte comes straight from the RAM on the last fetch cycle
	assign code = bns_pkg::note_code(letter_q, mark_q);
	assign octv = ram_rdata - bns_pkg::CH_ZERO;
	assign idx  = {4'd0, code} - 8'd1 + 8'(octv * 8'(bns_pkg::SEMITONES));

	assign ram_we    = in_accept && (kind == bns_pkg::KIND_WRITE);
	assign ram_waddr = addr_mod(song_addr);
	assign ram_raddr = (state_q == ST_IDLE) ? play_offset_q
	                                        : wrap_add(play_offset_q, {1'b0, fetch_cnt_q} + 3'd1);

	bns_ram #(
		.WIDTH(8),
		.DEPTH(SONG_DEPTH)
	) u_song_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(song_byte),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		nx_offset   = play_offset_q;
		nx_ticks    = note_ticks_q;
		nx_length   = note_length_q;
		nx_once     = music_once_q;
		nx_loop     = music_loop_q;
		nx_loaded   = song_loaded_q;
		nx_eff_act  = effect_active_q;
		nx_eff_sel  = effect_select_q;
		nx_eff_pos  = effect_pos_q;
		nx_gate     = gate_q;
		o_dv        = 1'b0;
		o_dval      = 16'd0;
		o_done      = 1'b0;
		load_out    = 1'b0;
		fetch_start = 1'b0;
		if (in_accept) begin
			case (kind)
				bns_pkg::KIND_TICK: begin
					if (effect_active_q) begin
						if (effect_pos_q < eff_len) begin
							if (fx_e == 8'd0) begin
								nx_gate = 1'b0;
							end else begin
								if (audio_enable_q) nx_gate = 1'b1;
								o_dv   = 1'b1;
								o_dval = bns_pkg::tone_of(fx_e);
							end
							nx_eff_pos = effect_pos_q + 5'd1;
						end else begin
							nx_gate    = 1'b0;
							nx_eff_act = 1'b0;
							nx_eff_pos = 5'd0;
						end
					end
					if (music_once_q || music_loop_q) begin
						if (note_ticks_q < note_length_q) begin
							nx_ticks = note_ticks_q + 8'd1;
						end else begin
							fetch_start = 1'b1;
						end
					end
					load_out = !fetch_start;
				end
				bns_pkg::KIND_WRITE: begin
					nx_offset = '0;
					nx_loaded = 1'b1;
					load_out  = 1'b1;
				end
				bns_pkg::KIND_PLAY: begin
					if (song_loaded_q) nx_once = 1'b1;
					load_out = 1'b1;
				end
				bns_pkg::KIND_LOOP: begin
					if (song_loaded_q) nx_loop = 1'b1;
					load_out = 1'b1;
				end
				bns_pkg::KIND_HALT, bns_pkg::KIND_UNLOAD: begin
					nx_gate    = 1'b0;
					nx_once    = 1'b0;
					nx_loop    = 1'b0;
					nx_eff_act = 1'b0;
					if (kind == bns_pkg::KIND_UNLOAD) nx_loaded = 1'b0;
					load_out = 1'b1;
				end
				bns_pkg::KIND_EFFECT: begin
					nx_eff_sel = (effect_id >= 8'd1 && effect_id <= 8'(bns_pkg::FX_COUNT))
					             ? 3'(effect_id - 8'd1) : 3'd0;
					nx_eff_pos = 5'(bns_pkg::FX_START_POS);
					nx_eff_act = 1'b1;
					load_out   = 1'b1;
				end
				default: begin
					load_out = 1'b1;
				end
			endcase
		end else if (fetch_last) begin
			// effect already stepped at accept; its divisor waits in pend_*
			o_dv      = pend_dv_q;
			o_dval    = pend_dval_q;
			load_out  = 1'b1;
			nx_offset = wrap_add(play_offset_q, 3'(bns_pkg::RECORD_LEN));
			if (dur_q != bns_pkg::END_MARK) begin
				nx_length = dur_q - bns_pkg::CH_ZERO;
				nx_ticks  = 8'd1;
				if (!effect_active_q) begin
					if (code == 4'd0) begin
						nx_gate = 1'b0;
					end else begin
						if (audio_enable_q) nx_gate = 1'b1;
						o_dv   = 1'b1;
						o_dval = bns_pkg::tone_of(idx);
					end
				end
			end else begin
				nx_ticks  = 8'd0;
				nx_length = 8'd0;
				if (music_loop_q) nx_offset = '0;
				if (music_once_q) begin
					nx_gate    = 1'b0;
					nx_once    = 1'b0;
					nx_loop    = 1'b0;
					nx_eff_act = 1'b0;
					o_done     = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			fetch_cnt_q     <= 2'd0;
			play_offset_q   <= '0;
			note_ticks_q    <= 8'd0;
			note_length_q   <= 8'd0;
			music_once_q    <= 1'b0;
			music_loop_q    <= 1'b0;
			song_loaded_q   <= 1'b0;
			effect_active_q <= 1'b0;
			effect_select_q <= 3'd0;
			effect_pos_q    <= 5'd0;
			gate_q          <= 1'b0;
			audio_enable_q  <= 1'b1;
			out_valid_q     <= 1'b0;
		end else begin
			play_offset_q   <= nx_offset;
			note_ticks_q    <= nx_ticks;
			note_length_q   <= nx_length;
			music_once_q    <= nx_once;
			music_loop_q    <= nx_loop;
			song_loaded_q   <= nx_loaded;
			effect_active_q <= nx_eff_act;
			effect_select_q <= nx_eff_sel;
			effect_pos_q    <= nx_eff_pos;
			gate_q          <= nx_gate;
			if (cfg_wr_en) audio_enable_q <= cfg_wr_data;
			case (state_q)
				ST_IDLE: begin
					if (fetch_start) begin
						state_q     <= ST_FETCH;
						fetch_cnt_q <= 2'd0;
					end
				end
				ST_FETCH: begin
					fetch_cnt_q <= fetch_cnt_q + 2'd1;
					if (fetch_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fetch_start) begin
			pend_dv_q   <= o_dv;
			pend_dval_q <= o_dval;
		end
		if (state_q == ST_FETCH) begin
			case (fetch_cnt_q)
				2'd0:    dur_q    <= ram_rdata;
				2'd1:    letter_q <= ram_rdata;
				2'd2:    mark_q   <= ram_rdata;
				default: ;
			endcase
		end
		if (load_out) begin
			out_gate_q <= nx_gate;
			out_dv_q   <= o_dv;
			out_dval_q <= o_dv ? o_dval : 16'd0;
			out_done_q <= o_done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, out_done_q, out_dval_q, out_gate_q};
	assign m_axis_tuser  = out_dv_q;

	// a record fetch only starts with an empty result slot
	a_fetch_slot_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> !out_valid_q)
		else $error("result slot busy during record fetch");

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, play_offset_q} < (AW+1)'(SONG_DEPTH))
		else $error("play offset beyond song memory");

	a_effect_pos: assert property (@(posedge clk) disable iff (!arst_n)
		effect_active_q |-> effect_pos_q <= eff_len)
		else $error("effect position past its row");

	a_done_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_done_q |-> !music_once_q && !gate_q && !effect_active_q)
		else $error("music done without halt");

	a_divisor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_dv_q |-> out_dval_q == 16'd0)
		else $error("divisor nonzero without divisor_valid");

endmodule

### rtl/bns_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
